[hdl/square_transposition_cipher_core_assert.svh]
// Assertion helpers shared by the cipher core modules.
`ifndef SQUARE_TRANSPOSITION_CIPHER_CORE_ASSERT_SVH
`define SQUARE_TRANSPOSITION_CIPHER_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define STC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define STC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/stc_pkg.sv]
`default_nettype none

package stc_pkg;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_SQRT,
		OP_READ,
		OP_EMIT,
		OP_SPACE,
		OP_EMPTY,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_LAST,
		C_ZERO,
		C_SQDONE,
		C_DONE,
		C_NOSPACE
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_CHKE  = 4'd1;
	localparam step_t ST_SQRT  = 4'd2;
	localparam step_t ST_RD    = 4'd3;
	localparam step_t ST_EMIT  = 4'd4;
	localparam step_t ST_TST   = 4'd5;
	localparam step_t ST_TSP   = 4'd6;
	localparam step_t ST_SPACE = 4'd7;
	localparam step_t ST_EMPTY = 4'd8;
	localparam step_t ST_FIN   = 4'd9;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] EMPTY_CHAR = 8'h00;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;     // stay on this step while the condition is false
		logic  need_out; // step waits for a free output register
		step_t jmp;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic go;
	} stc_ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic last_acc;
		logic n_zero;
		logic sq_done;
		logic run_done;
		logic space_due;
		logic out_free;
	} stc_status_t;

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		unique case (pc)
			ST_IDLE:  w = '{OP_LOAD,  C_LAST,    1'b1, 1'b0, ST_CHKE};
			ST_CHKE:  w = '{OP_INIT,  C_ZERO,    1'b0, 1'b0, ST_EMPTY};
			ST_SQRT:  w = '{OP_SQRT,  C_SQDONE,  1'b1, 1'b0, ST_RD};
			ST_RD:    w = '{OP_READ,  C_NEVER,   1'b0, 1'b0, ST_IDLE};
			ST_EMIT:  w = '{OP_EMIT,  C_NEVER,   1'b0, 1'b1, ST_IDLE};
			ST_TST:   w = '{OP_NOP,   C_DONE,    1'b0, 1'b0, ST_FIN};
			ST_TSP:   w = '{OP_NOP,   C_NOSPACE, 1'b0, 1'b0, ST_RD};
			ST_SPACE: w = '{OP_SPACE, C_ALWAYS,  1'b0, 1'b1, ST_RD};
			ST_EMPTY: w = '{OP_EMPTY, C_NEVER,   1'b0, 1'b1, ST_IDLE};
			ST_FIN:   w = '{OP_CLEAR, C_ALWAYS,  1'b0, 1'b0, ST_IDLE};
			default:  w = '{OP_NOP,   C_ALWAYS,  1'b0, 1'b0, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[hdl/stc_sequencer.sv]
`default_nettype none

module stc_sequencer import stc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire stc_status_t status,
	output stc_ctl_t         ctl
);

	`include "square_transposition_cipher_core_assert.svh"

	step_t  pc_q;
	ucode_t word;
	logic   stall;
	logic   cond_true;

	assign word  = ucode_rom(pc_q);
	assign stall = word.need_out && !status.out_free;

	always_comb begin
		unique case (word.cond)
			C_NEVER:   cond_true = 1'b0;
			C_ALWAYS:  cond_true = 1'b1;
			C_LAST:    cond_true = status.last_acc;
			C_ZERO:    cond_true = status.n_zero;
			C_SQDONE:  cond_true = status.sq_done;
			C_DONE:    cond_true = status.run_done;
			C_NOSPACE: cond_true = !status.space_due;
			default:   cond_true = 1'b0;
		endcase
	end

	assign ctl.op = word.op;
	assign ctl.go = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!stall) begin
			if (cond_true)
				pc_q <= word.jmp;
			else if (!word.hold)
				pc_q <= pc_q + 4'd1;
		end
	end

	`STC_ASSERT_NEXT(a_stall_holds, stall, $stable(pc_q), "step advanced while stalled")
	`STC_ASSERT(a_pc_range, pc_q <= ST_FIN, "step counter out of range")
	`STC_ASSERT_NEXT(a_last_starts, status.last_acc, pc_q == ST_CHKE, "closing word not taken up")

endmodule

`default_nettype wire

[hdl/stc_datapath.sv]
`default_nettype none

module stc_datapath import stc_pkg::*; #(
	parameter int unsigned MAX_CHARS = 48
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stc_ctl_t   ctl,
	input  wire logic       group_output,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       is_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            out_last,
	output logic            overflowed,
	output logic            empty_text,
	output stc_status_t     status
);

	`include "square_transposition_cipher_core_assert.svh"

	localparam int CNT_W  = $clog2(MAX_CHARS + 1);
	localparam int IDX_W  = CNT_W + 1;
	localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

	logic [7:0]       mem [MAX_CHARS];
	logic [7:0]       rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [CNT_W-1:0] side_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] emit_q;
	logic [CNT_W-1:0] grp_q;
	logic             out_valid_q;

	logic [7:0]         folded;
	logic               keep;
	logic               accept;
	logic               room;
	logic [2*CNT_W-1:0] sq;
	logic [IDX_W-1:0]   idx_sum;
	logic               wrap;
	logic [CNT_W-1:0]   col_inc;
	logic [CNT_W-1:0]   emit_inc;
	logic [CNT_W-1:0]   grp_inc;
	logic               out_free;
	logic               do_emit;
	logic               do_space;
	logic               do_empty;

	// case fold, then letters and digits only
	always_comb begin
		folded = in_char;
		if (in_char >= "A" && in_char <= "Z")
			folded = in_char + 8'h20;
	end
	assign keep = (folded >= "a" && folded <= "z") || (folded >= "0" && folded <= "9");

	assign in_ready = (ctl.op == OP_LOAD);
	assign accept   = in_ready && in_valid;
	assign room     = cnt_q < CNT_W'(MAX_CHARS);

	assign sq       = {{CNT_W{1'b0}}, side_q} * {{CNT_W{1'b0}}, side_q};
	// walk down a column; past the end, restart at top of next column
	assign idx_sum  = idx_q + {1'b0, side_q};
	assign wrap     = idx_sum >= {1'b0, cnt_q};
	assign col_inc  = col_q + 1'b1;
	assign emit_inc = emit_q + 1'b1;
	assign grp_inc  = grp_q + 1'b1;

	assign out_free = !out_valid_q || out_ready;
	assign do_emit  = ctl.go && (ctl.op == OP_EMIT);
	assign do_space = ctl.go && (ctl.op == OP_SPACE);
	assign do_empty = ctl.go && (ctl.op == OP_EMPTY);

	assign status.last_acc  = accept && is_last;
	assign status.n_zero    = (cnt_q == '0);
	assign status.sq_done   = sq >= {{CNT_W{1'b0}}, cnt_q};
	assign status.run_done  = (emit_q == cnt_q);
	assign status.space_due = group_output && (grp_q == '0);
	assign status.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (accept && keep && room)
			mem[cnt_q[ADDR_W-1:0]] <= folded;
		if (ctl.op == OP_READ)
			rd_q <= mem[idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && keep) begin
				if (room)
					cnt_q <= cnt_q + 1'b1;
				else
					ovf_q <= 1'b1;
			end
			if (ctl.op == OP_CLEAR) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (do_emit || do_space || do_empty)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_INIT) begin
			side_q <= '0;
			idx_q  <= '0;
			col_q  <= '0;
			emit_q <= '0;
			grp_q  <= '0;
		end
		if (ctl.op == OP_SQRT && !status.sq_done)
			side_q <= side_q + 1'b1;
		if (do_emit) begin
			out_char   <= rd_q;
			out_last   <= (emit_inc == cnt_q);
			overflowed <= ovf_q;
			empty_text <= 1'b0;
			emit_q     <= emit_inc;
			grp_q      <= (grp_inc == side_q) ? '0 : grp_inc;
			if (wrap) begin
				col_q <= col_inc;
				idx_q <= {1'b0, col_inc};
			end else begin
				idx_q <= idx_sum;
			end
		end
		if (do_space) begin
			out_char   <= SPACE_CHAR;
			out_last   <= 1'b0;
			overflowed <= ovf_q;
			empty_text <= 1'b0;
		end
		if (do_empty) begin
			out_char   <= EMPTY_CHAR;
			out_last   <= 1'b1;
			overflowed <= ovf_q;
			empty_text <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	`STC_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_CHARS), "char count above capacity")
	`STC_ASSERT(a_read_written, (ctl.op != OP_READ) || (idx_q < {1'b0, cnt_q}), "read past stored text")
	`STC_ASSERT(a_emit_bound, (ctl.op != OP_EMIT) || (emit_q < cnt_q), "more words than stored chars")
	`STC_ASSERT_NEXT(a_emit_loads, do_emit || do_space || do_empty, out_valid_q, "result word lost")

endmodule

`default_nettype wire

[hdl/square_transposition_cipher_core.sv]
`default_nettype none

// Crypto-square cipher. Text bytes load at one word per cycle; letters are folded
// to lower case, anything but letters and digits is dropped, and up to MAX_CHARS
// characters are kept (more sets the overflowed flag for the run). The word with
// is_last high closes the text; no input is taken until its whole result burst
// is loaded into the output register. A small microcoded sequencer then runs: a
// step to test for empty text, a narrow multiply-compare search for the square
// side (at most 7 for 48 characters), then per cipher character a store read, an
// output load and two branch steps (only the first for the final one), plus a
// space step per inserted space, and a final step to clear the store count. Empty
// text gives a single word with out_char 0 and empty_text set, loaded into the
// output register by the empty-text step after the test. Output stalls only hold
// the sequencer. group_output is written on the cfg channel and is always ready.
module square_transposition_cipher_core import stc_pkg::*; #(
	parameter int unsigned MAX_CHARS = 48
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       is_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            out_last,
	output logic            overflowed,
	output logic            empty_text
);

	logic        group_q;
	stc_ctl_t    ctl;
	stc_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			group_q <= 1'b0;
		else if (cfg_valid)
			group_q <= cfg_data;
	end

	stc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	stc_datapath #(
		.MAX_CHARS (MAX_CHARS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.group_output (group_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.out_last     (out_last),
		.overflowed   (overflowed),
		.empty_text   (empty_text),
		.status       (status)
	);

endmodule

`default_nettype wire
